/* rtl/core/console_uart_registers_core_macros.svh */
// Assertion helpers for the console serial line register block.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef CONSOLE_UART_REGISTERS_CORE_MACROS_SVH
`define CONSOLE_UART_REGISTERS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CUR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console uart check failed");

// Consequent must hold in the cycle after the antecedent.
`define CUR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console uart check failed");

`endif

/* rtl/core/cur_pkg.sv */
`default_nettype none
package cur_pkg;

    localparam int AGE_BITS   = 16;
    localparam int DATA_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int CSR_W      = 8;
    localparam int CFG_IDX_W  = 1;

    // input modes
    localparam logic [2:0] MODE_BUS_READ   = 3'd0;
    localparam logic [2:0] MODE_BUS_WRITE  = 3'd1;
    localparam logic [2:0] MODE_RX_CHAR    = 3'd2;
    localparam logic [2:0] MODE_RX_BREAK   = 3'd3;
    localparam logic [2:0] MODE_TX_DONE    = 3'd4;
    localparam logic [2:0] MODE_TICK       = 3'd5;

    // bus register indexes (address bits 4:2)
    localparam logic [2:0] REG_CSR  = 3'd0;
    localparam logic [2:0] REG_LPR  = 3'd1;
    localparam logic [2:0] REG_RBUF = 3'd2;
    localparam logic [2:0] REG_XBUF = 3'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_8BIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 1'd1;

    localparam logic [DATA_W-1:0] HOLD_TICKS_RESET = 16'd50;

    localparam int CS_XDONE_BIT = 0;
    localparam int CS_RDONE_BIT = 1;
    localparam logic [CSR_W-1:0]  CS_RESET  = 8'h01;
    localparam logic [DATA_W-1:0] RB_VALID  = 16'h8000;
    localparam logic [DATA_W-1:0] RB_FRAME  = 16'h2000;
    localparam logic [DATA_W-1:0] RB_BREAK  = 16'h0400;
    localparam logic [DATA_W-1:0] RB_CHAR   = 16'h00FF;

    typedef struct packed {
        logic [2:0]        mode;
        logic [4:0]        reg_addr;
        logic [DATA_W-1:0] write_data;
        logic [CHAR_W-1:0] rx_char;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              rx_taken;
        logic              tx_start;
        logic [CHAR_W-1:0] tx_char;
        logic              halt_request;
        logic              rx_irq;
        logic              tx_irq;
    } out_word_t;

    typedef struct packed {
        logic advance;
    } pipe_ctl_t;

    function automatic logic [CHAR_W-1:0] mask_char(input logic [CHAR_W-1:0] c,
                                                    input logic eight);
        mask_char = eight ? c : {1'b0, c[CHAR_W-2:0]};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/cur_in_stage.sv */
`default_nettype none
module cur_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire cur_pkg::in_word_t in_data,
    input  wire cur_pkg::pipe_ctl_t ctl,
    output logic                   item_valid,
    output cur_pkg::in_word_t      item
);

    logic              valid_reg, valid_next;
    cur_pkg::in_word_t item_reg;
    logic              accept;

    // holding word may leave this cycle, so a new one can enter
    assign in_stall = valid_reg && !ctl.advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

/* rtl/core/cur_regs.sv */
`default_nettype none
module cur_regs #(
    parameter int AGE_BITS = cur_pkg::AGE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [cur_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [cur_pkg::DATA_W-1:0]           cfg_data,
    input  wire cur_pkg::pipe_ctl_t                   ctl,
    input  wire cur_pkg::in_word_t                    item,
    output cur_pkg::out_word_t                        result
);

    localparam int CMP_W = (AGE_BITS > cur_pkg::DATA_W) ? AGE_BITS : cur_pkg::DATA_W;

    logic                        char_8bit_reg;
    logic [cur_pkg::DATA_W-1:0]  hold_ticks_reg;

    logic [cur_pkg::CSR_W-1:0]   cs_reg,   cs_next;
    logic [cur_pkg::DATA_W-1:0]  lpr_reg,  lpr_next;
    logic [cur_pkg::DATA_W-1:0]  rbuf_reg, rbuf_next;
    logic [cur_pkg::CHAR_W-1:0]  xbuf_reg, xbuf_next;
    logic [AGE_BITS-1:0]         age_reg,  age_next;
    logic                        rx_irq_reg, rx_irq_next;
    logic                        tx_irq_reg, tx_irq_next;

    logic [2:0]                  idx;
    logic                        rdone;
    logic                        rx_guard;
    logic [cur_pkg::CHAR_W-1:0]  rx_masked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_8bit_reg  <= 1'b1;
            hold_ticks_reg <= cur_pkg::HOLD_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cur_pkg::CFG_CHAR_8BIT:  char_8bit_reg  <= cfg_data[0];
                cur_pkg::CFG_HOLD_TICKS: hold_ticks_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign idx       = item.reg_addr[4:2];
    assign rdone     = cs_reg[cur_pkg::CS_RDONE_BIT];
    // pending character not yet old enough to be overwritten
    assign rx_guard  = rdone && (CMP_W'(age_reg) < CMP_W'(hold_ticks_reg));
    assign rx_masked = cur_pkg::mask_char(item.rx_char, char_8bit_reg);

    always_comb
    begin
        cs_next     = cs_reg;
        lpr_next    = lpr_reg;
        rbuf_next   = rbuf_reg;
        xbuf_next   = xbuf_reg;
        age_next    = age_reg;
        rx_irq_next = rx_irq_reg;
        tx_irq_next = tx_irq_reg;
        result      = '0;

        unique case (item.mode)
            cur_pkg::MODE_BUS_READ:
            begin
                unique case (idx)
                    cur_pkg::REG_CSR:  result.read_data = {8'h00, cs_reg};
                    cur_pkg::REG_LPR:  result.read_data = lpr_reg;
                    cur_pkg::REG_RBUF:
                    begin
                        result.read_data = rbuf_reg;
                        if (rdone)
                        begin
                            cs_next[cur_pkg::CS_RDONE_BIT] = 1'b0;
                            rbuf_next   = rbuf_reg & cur_pkg::RB_CHAR;
                            rx_irq_next = 1'b0;
                        end
                    end
                    cur_pkg::REG_XBUF: result.read_data = {8'h00, xbuf_reg};
                    default:           ;
                endcase
            end
            cur_pkg::MODE_BUS_WRITE:
            begin
                unique case (idx)
                    cur_pkg::REG_CSR:  cs_next  = item.write_data[cur_pkg::CSR_W-1:0];
                    cur_pkg::REG_LPR:  lpr_next = item.write_data;
                    cur_pkg::REG_RBUF: cs_next[cur_pkg::CS_RDONE_BIT] = 1'b0;
                    cur_pkg::REG_XBUF:
                    begin
                        xbuf_next = item.write_data[cur_pkg::CHAR_W-1:0];
                        cs_next[cur_pkg::CS_XDONE_BIT] = 1'b0;
                        tx_irq_next     = 1'b0;
                        result.tx_start = 1'b1;
                        result.tx_char  = cur_pkg::mask_char(
                            item.write_data[cur_pkg::CHAR_W-1:0], char_8bit_reg);
                    end
                    default:           ;
                endcase
            end
            cur_pkg::MODE_RX_CHAR:
            begin
                if (!rx_guard)
                begin
                    rbuf_next = cur_pkg::RB_VALID | {8'h00, rx_masked};
                    age_next  = '0;
                    cs_next[cur_pkg::CS_RDONE_BIT] = 1'b1;
                    rx_irq_next     = 1'b1;
                    result.rx_taken = 1'b1;
                end
            end
            cur_pkg::MODE_RX_BREAK:
            begin
                if (!rx_guard)
                begin
                    rbuf_next = cur_pkg::RB_VALID | cur_pkg::RB_FRAME | cur_pkg::RB_BREAK;
                    age_next  = '0;
                    cs_next[cur_pkg::CS_RDONE_BIT] = 1'b1;
                    rx_irq_next         = 1'b1;
                    result.rx_taken     = 1'b1;
                    result.halt_request = 1'b1;
                end
            end
            cur_pkg::MODE_TX_DONE:
            begin
                cs_next[cur_pkg::CS_XDONE_BIT] = 1'b1;
                tx_irq_next = 1'b1;
            end
            cur_pkg::MODE_TICK:
            begin
                if (age_reg != '1)
                begin
                    age_next = age_reg + 1'b1;
                end
            end
            default: ;
        endcase

        result.rx_irq = rx_irq_next;
        result.tx_irq = tx_irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg     <= cur_pkg::CS_RESET;
            lpr_reg    <= '0;
            rbuf_reg   <= '0;
            xbuf_reg   <= '0;
            age_reg    <= '0;
            rx_irq_reg <= 1'b0;
            tx_irq_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            cs_reg     <= cs_next;
            lpr_reg    <= lpr_next;
            rbuf_reg   <= rbuf_next;
            xbuf_reg   <= xbuf_next;
            age_reg    <= age_next;
            rx_irq_reg <= rx_irq_next;
            tx_irq_reg <= tx_irq_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/cur_out_stage.sv */
`default_nettype none
module cur_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cur_pkg::pipe_ctl_t ctl,
    input  wire cur_pkg::out_word_t result,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cur_pkg::out_word_t      out_data
);

    logic               valid_reg, valid_next;
    cur_pkg::out_word_t data_reg;

    assign room = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.advance)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* rtl/core/console_uart_registers_core.sv */
// Path: a word accepted into the input register passes on to the result register, where its
//   result word waits while the output side stalls.
// Throughput: one word per cycle while the output side does not stall; each word is a
//   single read-modify-write of the register file between the two registers.
// Reset (rst_n low, asynchronous): both stages empty, CSR = transmit done, other
//   registers zero, 8-bit characters, hold ticks 50.
`default_nettype none
module console_uart_registers_core #(
    parameter int AGE_BITS = cur_pkg::AGE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [cur_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cur_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire cur_pkg::in_word_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output cur_pkg::out_word_t                 out_data
);

    cur_pkg::pipe_ctl_t ctl;
    cur_pkg::in_word_t  item;
    cur_pkg::out_word_t result;
    logic               item_valid;
    logic               room;

    assign ctl.advance    = item_valid && room;

    cur_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .ctl        (ctl),
        .item_valid (item_valid),
        .item       (item)
    );

    cur_regs #(
        .AGE_BITS (AGE_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .item      (item),
        .result    (result)
    );

    cur_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .result    (result),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

/* rtl/core/cur_checker.sv */
`default_nettype none
`include "console_uart_registers_core_macros.svh"
module cur_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire cur_pkg::out_word_t out_data
);

    logic line_or_send;
    logic break_seen;

    assign line_or_send = out_data.rx_taken || out_data.tx_start;
    assign break_seen   = out_data.rx_taken && out_data.rx_irq;

    // a waiting result word holds until taken
    `CUR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // a send start always drops the transmit interrupt
    `CUR_ASSERT_SAME(a_tx_start_irq, out_valid && out_data.tx_start, !out_data.tx_irq)
    // a character goes out only on a send start
    `CUR_ASSERT_SAME(a_tx_char_idle, out_valid && !out_data.tx_start, out_data.tx_char == '0)
    // halt only on an accepted break, which raises the receive interrupt
    `CUR_ASSERT_SAME(a_halt_taken, out_valid && out_data.halt_request, break_seen)
    // a read returns nothing alongside line or send activity
    `CUR_ASSERT_SAME(a_read_excl, out_valid && line_or_send, out_data.read_data == '0)

endmodule

bind console_uart_registers_core cur_checker u_cur_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

/* tb/console_uart_registers_checker.sv */
`default_nettype none
module console_uart_registers_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [cur_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cur_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire cur_pkg::in_word_t             in_data,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire cur_pkg::out_word_t            out_data,
    output int                                 fail_count,
    output int                                 words_pending
);
    import cur_pkg::*;

    // register file image
    logic                eight_bit;
    logic [DATA_W-1:0]   hold_ticks;
    logic [CSR_W-1:0]    csr_q;
    logic [DATA_W-1:0]   lpr_q;
    logic [DATA_W-1:0]   rbuf_q;
    logic [CHAR_W-1:0]   xbuf_q;
    logic [AGE_BITS-1:0] rx_age_q;
    logic                rx_irq_q;
    logic                tx_irq_q;

    out_word_t due_results[$];

    task automatic report_error(input string msg);
        $display("%0t checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic logic [CHAR_W-1:0] line_char(input logic [CHAR_W-1:0] c);
        line_char = eight_bit ? c : (c & 8'h7f);
    endfunction

    task automatic latch_rx(input logic [DATA_W-1:0] value);
        rbuf_q = value | RB_VALID;
        rx_age_q = '0;
        csr_q[CS_RDONE_BIT] = 1'b1;
        rx_irq_q = 1'b1;
    endtask

    task automatic run_register_access(input in_word_t w);
        out_word_t  r;
        logic [2:0] idx;
        logic       guarded;
        r = '0;
        idx = w.reg_addr[4:2];
        // pending char is kept until its hold time runs out
        guarded = csr_q[CS_RDONE_BIT] && ({16'd0, rx_age_q} < {16'd0, hold_ticks});
        case (w.mode)
            MODE_BUS_READ:
                case (idx)
                    REG_CSR:  r.read_data = {8'h00, csr_q};
                    REG_LPR:  r.read_data = lpr_q;
                    REG_RBUF:
                    begin
                        r.read_data = rbuf_q;
                        if (csr_q[CS_RDONE_BIT])
                        begin
                            csr_q[CS_RDONE_BIT] = 1'b0;
                            rbuf_q = rbuf_q & RB_CHAR;
                            rx_irq_q = 1'b0;
                        end
                    end
                    REG_XBUF: r.read_data = {8'h00, xbuf_q};
                    default:  r.read_data = '0;
                endcase
            MODE_BUS_WRITE:
                case (idx)
                    REG_CSR:  csr_q = w.write_data[CSR_W-1:0];
                    REG_LPR:  lpr_q = w.write_data;
                    REG_RBUF: csr_q[CS_RDONE_BIT] = 1'b0;
                    REG_XBUF:
                    begin
                        xbuf_q = w.write_data[CHAR_W-1:0];
                        csr_q[CS_XDONE_BIT] = 1'b0;
                        tx_irq_q = 1'b0;
                        r.tx_start = 1'b1;
                        r.tx_char = line_char(xbuf_q);
                    end
                    default: ;
                endcase
            MODE_RX_CHAR:
                if (!guarded)
                begin
                    latch_rx({8'h00, line_char(w.rx_char)});
                    r.rx_taken = 1'b1;
                end
            MODE_RX_BREAK:
                if (!guarded)
                begin
                    latch_rx(RB_FRAME | RB_BREAK);
                    r.rx_taken = 1'b1;
                    r.halt_request = 1'b1;
                end
            MODE_TX_DONE:
            begin
                csr_q[CS_XDONE_BIT] = 1'b1;
                tx_irq_q = 1'b1;
            end
            MODE_TICK:
                if (rx_age_q != '1)
                    rx_age_q = rx_age_q + 1'b1;
            default: ;
        endcase
        r.rx_irq = rx_irq_q;
        r.tx_irq = tx_irq_q;
        due_results.push_back(r);
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            eight_bit = 1'b1;
            hold_ticks = HOLD_TICKS_RESET;
            csr_q = CS_RESET;
            lpr_q = '0;
            rbuf_q = '0;
            xbuf_q = '0;
            rx_age_q = '0;
            rx_irq_q = 1'b0;
            tx_irq_q = 1'b0;
            fail_count = 0;
            due_results.delete();
            words_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    report_error($sformatf("unexpected word %h", out_data));
                else
                begin
                    want = due_results.pop_front();
                    check_field("read_data", out_data.read_data, want.read_data);
                    check_field("rx_taken", out_data.rx_taken, want.rx_taken);
                    check_field("tx_start", out_data.tx_start, want.tx_start);
                    check_field("tx_char", out_data.tx_char, want.tx_char);
                    check_field("halt_request", out_data.halt_request, want.halt_request);
                    check_field("rx_irq", out_data.rx_irq, want.rx_irq);
                    check_field("tx_irq", out_data.tx_irq, want.tx_irq);
                end
            end
            if (cfg_write)
                case (cfg_index)
                    CFG_CHAR_8BIT:  eight_bit = cfg_data[0];
                    CFG_HOLD_TICKS: hold_ticks = cfg_data;
                    default: ;
                endcase
            if (in_valid && !in_stall)
                run_register_access(in_data);
            words_pending <= due_results.size();
        end
    end
endmodule
`default_nettype wire

/* tb/tb_console_uart_registers_core.sv */
`default_nettype none
module tb_console_uart_registers_core;
    import cur_pkg::*;

    localparam int LONG_HOLD       = 90;
    localparam int SETTLE_CYCLES   = 6;
    localparam int ITEMS_PER_PHASE = 180;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_word_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_data;
    int                   fail_count;
    int                   words_pending;

    always #5 clk = ~clk;

    console_uart_registers_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    console_uart_registers_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // offer a word and hold it until it is taken
    task automatic send_word(input in_word_t w);
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [2:0] mode, input logic [4:0] addr,
                               input logic [15:0] data, input logic [7:0] ch);
        in_word_t w;
        w.mode = mode;
        w.reg_addr = addr;
        w.write_data = data;
        w.rx_char = ch;
        send_word(w);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // sender waits until every result word is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic eight, input logic [15:0] hold);
        cfg_write <= 1'b1;
        cfg_index <= CFG_CHAR_8BIT;
        cfg_data <= {15'($urandom_range(0, 32767)), eight};
        @(posedge clk);
        cfg_index <= CFG_HOLD_TICKS;
        cfg_data <= hold;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic in_word_t random_word();
        in_word_t   w;
        int         pick;
        logic [2:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 24)
            w.mode = MODE_BUS_READ;
        else if (pick < 44)
            w.mode = MODE_BUS_WRITE;
        else if (pick < 64)
            w.mode = MODE_RX_CHAR;
        else if (pick < 70)
            w.mode = MODE_RX_BREAK;
        else if (pick < 80)
            w.mode = MODE_TX_DONE;
        else if (pick < 95)
            w.mode = MODE_TICK;
        else
            w.mode = 3'($urandom_range(6, 7));
        // unmapped indexes now and then
        if ($urandom_range(0, 15) == 0)
            idx = 3'($urandom_range(4, 7));
        else
            idx = 3'($urandom_range(0, 3));
        w.reg_addr = {idx, 2'($urandom_range(0, 3))};
        w.write_data = 16'($urandom);
        w.rx_char = 8'($urandom);
        random_word = w;
    endfunction

    task automatic run_random(input int count);
        int       sent;
        int       burst;
        int       k;
        int       ticks;
        in_word_t w;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst; k++)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    // send a run of ticks to age a pending char toward its hold time
                    ticks = $urandom_range(4, 60);
                    repeat (ticks)
                    begin
                        w = random_word();
                        w.mode = MODE_TICK;
                        send_word(w);
                    end
                    sent += ticks;
                end
                else
                begin
                    send_word(random_word());
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
        end
    endtask

    initial
    begin : receiver
        int seg;
        int len;
        int kind;
        int k;
        seg = 0;
        @(posedge clk);
        forever
        begin
            seg++;
            len = $urandom_range(5, 40);
            kind = $urandom_range(0, 2);
            if (seg % 12 == 5)
            begin
                kind = 3;
                len = LONG_HOLD;
            end
            for (k = 0; k < len; k++)
            begin
                case (kind)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= 1'b1;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        #2000000;
        $display("[console_uart_registers_core] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, unmapped indexes and modes, receive and transmit corners
        send_fields(MODE_BUS_READ, 5'd0, 16'h0000, 8'h00);
        send_fields(MODE_BUS_READ, 5'd4, 16'hffff, 8'hff);
        send_fields(MODE_BUS_READ, 5'd8, 16'h0000, 8'h00);
        send_fields(MODE_BUS_READ, 5'd12, 16'h0000, 8'h00);
        send_fields(MODE_BUS_READ, 5'd16, 16'h0000, 8'h00);
        send_fields(MODE_BUS_READ, 5'd31, 16'hffff, 8'hff);
        send_fields(MODE_BUS_WRITE, 5'd5, 16'hffff, 8'h00);
        send_fields(MODE_BUS_READ, 5'd6, 16'h0000, 8'h00);
        send_fields(MODE_BUS_WRITE, 5'd4, 16'h0000, 8'h00);
        send_fields(MODE_BUS_WRITE, 5'd20, 16'hffff, 8'hff);
        send_fields(MODE_RX_CHAR, 5'd0, 16'h0000, 8'hff);
        send_fields(MODE_RX_CHAR, 5'd0, 16'h0000, 8'h00);
        send_fields(MODE_RX_BREAK, 5'd0, 16'h0000, 8'h00);
        send_fields(MODE_BUS_READ, 5'd9, 16'h0000, 8'h00);
        send_fields(MODE_BUS_READ, 5'd10, 16'h0000, 8'h00);
        send_fields(MODE_RX_BREAK, 5'd31, 16'hffff, 8'hff);
        send_fields(MODE_BUS_WRITE, 5'd11, 16'h0000, 8'h00);
        send_fields(MODE_BUS_READ, 5'd3, 16'h0000, 8'h00);
        send_fields(MODE_BUS_WRITE, 5'd12, 16'hffff, 8'h00);
        send_fields(MODE_TX_DONE, 5'd0, 16'h0000, 8'h00);
        send_fields(MODE_TX_DONE, 5'd0, 16'h0000, 8'h00);
        send_fields(MODE_TICK, 5'd0, 16'h0000, 8'h00);
        send_fields(3'd6, 5'd8, 16'hffff, 8'hff);
        send_fields(3'd7, 5'd12, 16'hffff, 8'hff);
        send_fields(MODE_BUS_WRITE, 5'd0, 16'hffff, 8'h00);
        send_fields(MODE_BUS_READ, 5'd15, 16'h0000, 8'h00);
        drain();

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:       write_settings(1'b0, 16'd0);
                1:       write_settings(1'b1, 16'hffff);
                2:       write_settings(1'b0, 16'd3);
                3:       write_settings(1'b1, HOLD_TICKS_RESET);
                4:       write_settings(1'b1, 16'd1);
                default: write_settings(1'b0, 16'($urandom_range(0, 80)));
            endcase
            run_random(ITEMS_PER_PHASE);
            drain();
        end

        if (fail_count == 0)
            $display("[console_uart_registers_core] OK");
        else
            $display("[console_uart_registers_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/cur_pkg.sv
rtl/core/cur_in_stage.sv
rtl/core/cur_regs.sv
rtl/core/cur_out_stage.sv
rtl/core/console_uart_registers_core.sv
rtl/core/cur_checker.sv
tb/console_uart_registers_checker.sv
tb/tb_console_uart_registers_core.sv
